### rtl/fsht_pkg.sv
// fsht_pkg: shared constants and types of the field schema hash table
// table size, hash constants, mode codes, stored pair layout
// no dependencies
`timescale 1ns / 1ps

package fsht_pkg;

	// table size and derived widths
	localparam int MAX_FIELDS = 32;
	localparam int CNT_W      = $clog2(MAX_FIELDS + 1);
	localparam int ADDR_W     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	// field widths
	localparam int ID_W  = 32;
	localparam int OFF_W = 31;

	// fnv-1a constants
	localparam logic [31:0] SEED_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
	localparam logic [7:0]  BYTE_MASK  = 8'hFF;

	// mode codes
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_EMIT  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// one stored (id, offset) pair
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [OFF_W-1:0] off;
	} pair_t;

	localparam int PAIR_W = $bits(pair_t);

	// status of the hash fold unit
	typedef struct packed {
		logic running;
		logic done;
	} hash_stat_t;

endpackage

### rtl/fsht_ram.sv
// fsht_ram: generic single-port-write, single-port-read ram
// registered read, no reset on the array
// no dependencies
`timescale 1ns / 1ps

module fsht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fsht_hash.sv
// fsht_hash: iterative fnv-1a fold of one 32-bit id, one byte per cycle
// four steps, low byte first, seeded with the offset basis when the hash is zero
// depends on fsht_pkg
`timescale 1ns / 1ps

module fsht_hash (
	input  logic                hash_clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         hash_in,
	input  logic [31:0]         id_in,
	output fsht_pkg::hash_stat_t stat,
	output logic [31:0]         hash_out
);

	logic [31:0] h_q;
	logic [31:0] id_q;
	logic [1:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] mix;
	logic [31:0] prod;

	// xor the low byte in, then multiply by the prime mod 2^32
	assign mix  = h_q ^ {24'd0, id_q[7:0] & fsht_pkg::BYTE_MASK};
	assign prod = mix * fsht_pkg::HASH_PRIME;

	always_ff @(posedge hash_clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 2'd0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge hash_clk) begin
		if (start) begin
			h_q  <= (hash_in == 32'd0) ? fsht_pkg::SEED_BASIS : hash_in;
			id_q <= id_in;
		end else if (run_q) begin
			h_q  <= prod;
			id_q <= {8'd0, id_q[31:8]};
		end
	end

	assign stat.running = run_q;
	assign stat.done    = done_q;
	assign hash_out     = h_q;

endmodule

### rtl/field_schema_hash_table.sv
// field_schema_hash_table: schema builder with a running fnv-1a hash over field ids
// top level: command port, pair table in fsht_ram, hash fold in fsht_hash
// depends on fsht_pkg, fsht_ram, fsht_hash
`timescale 1ns / 1ps

// usage
//   a command word (mode, field_id, field_offset) is taken at a rising edge with
//   start high and busy low. every result word is shown for exactly one cycle
//   with done high; the receiver cannot hold results off, so none is ever held.
//   mode add   : stores the pair and folds the id into the hash, four multiply
//                steps in the fold unit, one per cycle. done follows the end of
//                the fold through the output register; busy is high until then.
//   add, table full : refused at once, one word with table_full, next cycle.
//   mode emit  : walks the pair ram one address per cycle, one word per stored
//                pair, last on the final one. each pair passes the ram read and
//                the output register on its way out. an empty table gives one
//                word with is_empty, next cycle.
//   mode clear / unused code : one status word next cycle, busy stays low,
//                so a new command may follow in the very next cycle.
//   reset: hash and pair count go to zero, no word is pending. the ram is not
//   cleared; only entries below the count are ever read.

module field_schema_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] field_id,
	input  logic [30:0] field_offset,
	output logic        done,
	output logic [31:0] schema_hash,
	output logic        pair_valid,
	output logic [31:0] pair_id,
	output logic [30:0] pair_offset,
	output logic        is_empty,
	output logic        table_full,
	output logic        last
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                    state_q;
	logic [31:0]                   hash_q;
	logic [fsht_pkg::CNT_W-1:0]    count_q;
	logic [fsht_pkg::ADDR_W-1:0]   idx_q;

	// read pipeline stage: a ram word is on its way
	logic                          rd_s1;
	logic                          last_s1;

	logic                          accept;
	logic                          full_now;
	logic                          add_ok;
	logic                          emit_last;

	fsht_pkg::pair_t               wr_pair;
	fsht_pkg::pair_t               rd_pair;
	logic                          ram_re;

	fsht_pkg::hash_stat_t          hstat;
	logic [31:0]                   hash_res;

	// output word registers
	logic                          done_q;
	logic [31:0]                   o_hash_q;
	logic                          o_pv_q;
	logic [31:0]                   o_id_q;
	logic [30:0]                   o_off_q;
	logic                          o_empty_q;
	logic                          o_full_q;
	logic                          o_last_q;

	// next output word
	logic                          load_out;
	logic [31:0]                   n_hash;
	logic                          n_pv;
	logic [31:0]                   n_id;
	logic [30:0]                   n_off;
	logic                          n_empty;
	logic                          n_full;
	logic                          n_last;

	// busy also covers the read still in flight, so a single-word command
	// never lands on the output register in the same cycle as a pair
	assign busy     = (state_q != ST_IDLE) || rd_s1;
	assign accept   = start && !busy;
	assign full_now = (count_q >= fsht_pkg::CNT_W'(fsht_pkg::MAX_FIELDS));
	assign add_ok   = accept && (mode == fsht_pkg::MODE_ADD) && !full_now;

	// final address of an emit walk
	assign emit_last = ((fsht_pkg::CNT_W'(idx_q) + fsht_pkg::CNT_W'(1)) == count_q);
	assign ram_re    = (state_q == ST_EMIT);

	assign wr_pair.id  = field_id;
	assign wr_pair.off = field_offset;

	// pair table; write and read never meet since emit and add are serialized
	fsht_ram #(
		.WIDTH (fsht_pkg::PAIR_W),
		.DEPTH (fsht_pkg::MAX_FIELDS)
	) u_pair_ram (
		.clk   (clk),
		.we    (add_ok),
		.waddr (count_q[fsht_pkg::ADDR_W-1:0]),
		.wdata (wr_pair),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_pair)
	);

	// hash fold unit, started with the hash as it stands now
	fsht_hash u_hash (
		.hash_clk (clk),
		.arst_n   (arst_n),
		.start    (add_ok),
		.hash_in  (hash_q),
		.id_in    (field_id),
		.stat     (hstat),
		.hash_out (hash_res)
	);

	// pick the word for the output register
	always_comb begin
		load_out = 1'b0;
		n_hash   = hash_q;
		n_pv     = 1'b0;
		n_id     = 32'd0;
		n_off    = 31'd0;
		n_empty  = (count_q == '0);
		n_full   = 1'b0;
		n_last   = 1'b1;
		if (rd_s1) begin
			// one stored pair of an emit walk
			load_out = 1'b1;
			n_pv     = 1'b1;
			n_id     = rd_pair.id;
			n_off    = rd_pair.off;
			n_empty  = 1'b0;
			n_last   = last_s1;
		end else if (hstat.done) begin
			// add finished: new hash, table now holds at least one pair
			load_out = 1'b1;
			n_hash   = hash_res;
			n_empty  = 1'b0;
		end else if (accept) begin
			case (mode)
				fsht_pkg::MODE_ADD: begin
					if (full_now) begin
						load_out = 1'b1;
						n_full   = 1'b1;
					end
				end
				fsht_pkg::MODE_EMIT: begin
					if (count_q == '0) begin
						load_out = 1'b1;
					end
				end
				fsht_pkg::MODE_CLEAR: begin
					load_out = 1'b1;
					n_hash   = 32'd0;
					n_empty  = 1'b1;
				end
				default: begin
					// unused code: status word only
					load_out = 1'b1;
				end
			endcase
		end
	end

	// control: sequencer, hash, count, read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q  <= 32'd0;
			count_q <= '0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= load_out;
			rd_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							fsht_pkg::MODE_ADD: begin
								if (!full_now) begin
									count_q <= count_q + fsht_pkg::CNT_W'(1);
									state_q <= ST_ADD;
								end
							end
							fsht_pkg::MODE_EMIT: begin
								if (count_q != '0) begin
									idx_q   <= '0;
									state_q <= ST_EMIT;
								end
							end
							fsht_pkg::MODE_CLEAR: begin
								hash_q  <= 32'd0;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: begin
					if (hstat.done) begin
						hash_q  <= hash_res;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					// one read a cycle; the data comes out of the ram next cycle
					rd_s1   <= 1'b1;
					last_s1 <= emit_last;
					if (emit_last) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + fsht_pkg::ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			o_hash_q  <= n_hash;
			o_pv_q    <= n_pv;
			o_id_q    <= n_id;
			o_off_q   <= n_off;
			o_empty_q <= n_empty;
			o_full_q  <= n_full;
			o_last_q  <= n_last;
		end
	end

	assign done        = done_q;
	assign schema_hash = o_hash_q;
	assign pair_valid  = o_pv_q;
	assign pair_id     = o_id_q;
	assign pair_offset = o_off_q;
	assign is_empty    = o_empty_q;
	assign table_full  = o_full_q;
	assign last        = o_last_q;

	// the fold unit only runs while the sequencer waits on it
	a_hash_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		(hstat.running || hstat.done) |-> (state_q == ST_ADD))
		else $error("hash unit active outside an add");

	// the pair count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fsht_pkg::CNT_W'(fsht_pkg::MAX_FIELDS))
		else $error("pair count beyond table size");

	// every ram word on its way becomes a pair word in the next cycle
	a_read_to_word: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |=> (done && pair_valid && !is_empty && !table_full))
		else $error("ram read did not produce a pair word");

	// a final pair ends the walk and frees the port
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_s1 && last_s1) |=> !busy)
		else $error("busy stuck after final pair");

endmodule

### verif/fsht_checker.sv
// fsht_checker: watches the command and result ports of field_schema_hash_table
// keeps its own schema hash, pair count and pair table, predicts every result word
// depends on fsht_pkg
`timescale 1ns / 1ps

module fsht_checker
	import fsht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] field_id,
	input  logic [30:0] field_offset,
	input  logic        done,
	input  logic [31:0] schema_hash,
	input  logic        pair_valid,
	input  logic [31:0] pair_id,
	input  logic [30:0] pair_offset,
	input  logic        is_empty,
	input  logic        table_full,
	input  logic        last,
	output int          mismatch_count,
	output int          owed_words
);

	typedef struct packed {
		logic [31:0]      hash;
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [OFF_W-1:0] off;
		logic             empty;
		logic             full;
		logic             last;
	} schema_word_t;

	logic [31:0]      run_hash;
	logic [CNT_W-1:0] field_count;
	pair_t            stored_pairs [MAX_FIELDS];
	schema_word_t     owed_q [$];

	function automatic logic [31:0] fold_field_id(logic [31:0] h, logic [31:0] id);
		logic [31:0] acc;
		int b;
		acc = (h == 32'd0) ? SEED_BASIS : h;
		for (b = 0; b < 4; b++)
			acc = (acc ^ {24'd0, id[8*b +: 8] & BYTE_MASK}) * HASH_PRIME;
		return acc;
	endfunction

	task automatic owe_word(logic valid, pair_t p, logic empty, logic full, logic fin);
		schema_word_t w;
		w.hash  = run_hash;
		w.valid = valid;
		w.id    = p.id;
		w.off   = p.off;
		w.empty = empty;
		w.full  = full;
		w.last  = fin;
		owed_q.insert(owed_q.size(), w);
	endtask

	task automatic predict_command(logic [1:0] m, logic [31:0] id, logic [30:0] off);
		int i;
		case (m)
			MODE_ADD: begin
				if (field_count >= MAX_FIELDS) begin
					owe_word(1'b0, '0, field_count == 0, 1'b1, 1'b1);
				end else begin
					run_hash = fold_field_id(run_hash, id);
					stored_pairs[field_count[ADDR_W-1:0]] = '{id: id, off: off};
					field_count = field_count + 1'b1;
					owe_word(1'b0, '0, 1'b0, 1'b0, 1'b1);
				end
			end
			MODE_EMIT: begin
				if (field_count == 0)
					owe_word(1'b0, '0, 1'b1, 1'b0, 1'b1);
				for (i = 0; i < field_count; i++)
					owe_word(1'b1, stored_pairs[i], 1'b0, 1'b0, i == field_count - 1);
			end
			MODE_CLEAR: begin
				run_hash    = '0;
				field_count = '0;
				owe_word(1'b0, '0, 1'b1, 1'b0, 1'b1);
			end
			default: begin
				// spare code: status word only
				owe_word(1'b0, '0, field_count == 0, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		schema_word_t w;
		if (!arst_n) begin
			run_hash       = '0;
			field_count    = '0;
			mismatch_count = 0;
			owed_q.delete();
			owed_words     = 0;
		end else begin
			// a word on the ports belongs to an earlier command, so check it first
			if (done) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual hash %h id %h",
						$time, schema_hash, pair_id);
					mismatch_count++;
				end else begin
					w = owed_q.pop_front();
					check_field("schema_hash", w.hash, schema_hash);
					check_field("pair_valid", 32'(w.valid), 32'(pair_valid));
					check_field("pair_id", w.id, pair_id);
					check_field("pair_offset", 32'(w.off), 32'(pair_offset));
					check_field("is_empty", 32'(w.empty), 32'(is_empty));
					check_field("table_full", 32'(w.full), 32'(table_full));
					check_field("last", 32'(w.last), 32'(last));
				end
			end
			if (start && !busy)
				predict_command(mode, field_id, field_offset);
			owed_words = owed_q.size();
		end
	end

endmodule

### verif/tb.sv
// tb: stimulus and verdict for field_schema_hash_table
// directed corner words, then random schema-building sequences under varying sender gaps
// depends on fsht_pkg, fsht_checker, field_schema_hash_table
`timescale 1ns / 1ps

module tb;
	import fsht_pkg::*;

	// code the block treats as a plain status request
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// stop issuing once this many command words went in
	localparam int WORD_TARGET = 120;
	// generous bound: ~125 words, each up to a full emit plus the longest sender gap
	localparam int CYCLE_LIMIT = 100000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_ADD;
	logic [31:0] field_id = '0;
	logic [30:0] field_offset = '0;

	logic        busy;
	logic        done;
	logic [31:0] schema_hash;
	logic        pair_valid;
	logic [31:0] pair_id;
	logic [30:0] pair_offset;
	logic        is_empty;
	logic        table_full;
	logic        last;

	int mismatch_count;
	int owed_words;
	int words_issued = 0;
	int cycle_count = 0;

	// lookup of states two byte steps away from a zero hash, keyed by bits 23:8
	bit [32:0]   zero_slots [0:65535];
	logic [31:0] prime_inv;

	always #4 clk = ~clk;

	field_schema_hash_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.field_id     (field_id),
		.field_offset (field_offset),
		.done         (done),
		.schema_hash  (schema_hash),
		.pair_valid   (pair_valid),
		.pair_id      (pair_id),
		.pair_offset  (pair_offset),
		.is_empty     (is_empty),
		.table_full   (table_full),
		.last         (last)
	);

	fsht_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.field_id       (field_id),
		.field_offset   (field_offset),
		.done           (done),
		.schema_hash    (schema_hash),
		.pair_valid     (pair_valid),
		.pair_id        (pair_id),
		.pair_offset    (pair_offset),
		.is_empty       (is_empty),
		.table_full     (table_full),
		.last           (last),
		.mismatch_count (mismatch_count),
		.owed_words     (owed_words)
	);

	// watchdog: a hang or a missing word ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one fnv-1a byte step, no seeding
	function automatic logic [31:0] fnv_byte(logic [31:0] h, logic [7:0] b);
		return (h ^ {24'd0, b}) * HASH_PRIME;
	endfunction

	// meet in the middle: two bytes forward from h0, two bytes back from a zero hash
	// the last step zeroes the hash when the state before it equals its byte, so the
	// state after two bytes must be k * inverse prime with its low byte xored away
	function automatic bit find_zero_id(input logic [31:0] h0, output logic [31:0] id);
		logic [31:0] h2;
		logic [31:0] t;
		bit [32:0]   slot;
		int          b0;
		int          b1;
		id = '0;
		for (b0 = 0; b0 < 256; b0++) begin
			for (b1 = 0; b1 < 256; b1++) begin
				h2   = fnv_byte(fnv_byte(h0, b0[7:0]), b1[7:0]);
				slot = zero_slots[h2[23:8]];
				if (slot[32] && slot[31:8] == h2[31:8]) begin
					t  = {24'd0, slot[7:0]} * prime_inv;
					id = {slot[7:0], h2[7:0] ^ t[7:0], b1[7:0], b0[7:0]};
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// present one command word and hold it until the block takes it;
	// a gap before it is drawn from the current idle rate
	task automatic issue_word(logic [1:0] m, logic [31:0] id, logic [30:0] off);
		int idle_pct;
		idle_pct = (words_issued < 40) ? 9 : (words_issued < 80) ? 82 : 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		field_id     <= id;
		field_offset <= off;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_issued++;
	endtask

	initial begin
		logic [31:0] t;
		logic [31:0] seed;
		logic [31:0] prefix_id;
		logic [31:0] zero_id;
		bit          zero_found;
		int          zero_prefix;
		int          k;
		int          p;
		int          b;
		int          target;
		int          n;
		int          pick;

		// inverse of the prime mod 2^32 by newton steps
		prime_inv = HASH_PRIME;
		repeat (5) prime_inv = prime_inv * (32'd2 - HASH_PRIME * prime_inv);
		for (k = 0; k < 256; k++) begin
			t = k * prime_inv;
			zero_slots[t[23:8]] = {1'b1, t[31:8], k[7:0]};
		end

		// find an id that folds the hash to zero, from the seeded state after a clear
		// or after one prefix add when the seeded state has no solution
		zero_found  = 1'b0;
		zero_prefix = 0;
		prefix_id   = '0;
		for (p = 0; p < 12 && !zero_found; p++) begin
			prefix_id = p * 32'h9E37_79B9;
			seed      = SEED_BASIS;
			if (p != 0)
				for (b = 0; b < 4; b++)
					seed = fnv_byte(seed, prefix_id[8*b +: 8]);
			zero_found  = find_zero_id(seed, zero_id);
			zero_prefix = p;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, spare code, bit extremes of id and offset
		issue_word(MODE_EMIT, $urandom, $urandom);
		issue_word(MODE_SPARE, $urandom, $urandom);
		issue_word(MODE_CLEAR, $urandom, $urandom);
		issue_word(MODE_ADD, 32'h0000_0000, 31'h0000_0000);
		issue_word(MODE_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		issue_word(MODE_ADD, 32'h5555_5555, 31'h2AAA_AAAA);
		issue_word(MODE_ADD, 32'hAAAA_AAAA, 31'h5555_5555);
		issue_word(MODE_EMIT, $urandom, $urandom);
		issue_word(MODE_SPARE, $urandom, $urandom);
		issue_word(MODE_CLEAR, $urandom, $urandom);
		issue_word(MODE_EMIT, $urandom, $urandom);

		// hash driven to zero, shown by a status word, then reseeded by the next add
		if (zero_found) begin
			if (zero_prefix != 0)
				issue_word(MODE_ADD, prefix_id, $urandom);
			issue_word(MODE_ADD, zero_id, $urandom);
			issue_word(MODE_SPARE, $urandom, $urandom);
			issue_word(MODE_ADD, $urandom, $urandom);
			issue_word(MODE_EMIT, $urandom, $urandom);
			issue_word(MODE_CLEAR, $urandom, $urandom);
		end

		// random schemas: clear, a run of adds with emits and status words mixed in,
		// now and then a clear in the middle, then a final emit; the first schema and
		// about a quarter of the others are given more adds than the table holds
		n = 0;
		while (words_issued < WORD_TARGET) begin
			if (n == 0 || $urandom_range(0, 3) == 0)
				target = MAX_FIELDS + $urandom_range(1, 3);
			else
				target = $urandom_range(1, 12);
			n++;
			issue_word(MODE_CLEAR, $urandom, $urandom);
			for (k = 0; k < target && words_issued < WORD_TARGET; k++) begin
				issue_word(MODE_ADD, $urandom, $urandom);
				pick = $urandom_range(0, 99);
				if (pick < 12)
					issue_word(MODE_EMIT, $urandom, $urandom);
				else if (pick < 16)
					issue_word(MODE_SPARE, $urandom, $urandom);
				else if (pick < 19)
					issue_word(MODE_CLEAR, $urandom, $urandom);
			end
			issue_word(MODE_EMIT, $urandom, $urandom);
		end

		// drain: every owed word must arrive, then watch for strays a full emit long
		start <= 1'b0;
		@(posedge clk);
		while (owed_words != 0) @(posedge clk);
		repeat (MAX_FIELDS + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### field_schema_hash_table.f
rtl/fsht_pkg.sv
rtl/fsht_ram.sv
rtl/fsht_hash.sv
rtl/field_schema_hash_table.sv
verif/fsht_checker.sv
verif/tb.sv
